/* rtl/dkpt_pkg.sv */
// Shared types, constants and saturation helpers for the damped Kalman position tracker.
// No dependencies; every module of the tracker imports this package.
package dkpt_pkg;

  localparam int unsigned CfgIdxW = 3;

  localparam logic [CfgIdxW-1:0] CFG_ACCEL_NOISE   = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_DAMPING       = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_FULL_NOISE    = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_BIN_SCALE     = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_BIAS_LOW      = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_BIAS_HIGH     = 3'd5;
  localparam logic [CfgIdxW-1:0] CFG_VARIANCE_LOW  = 3'd6;
  localparam logic [CfgIdxW-1:0] CFG_VARIANCE_HIGH = 3'd7;

  localparam logic [31:0] ACCEL_NOISE_RST = 32'd16777;
  localparam logic [16:0] DAMPING_RST     = 17'd65536;
  localparam logic [31:0] FULL_NOISE_RST  = 32'd1677722;
  localparam logic [15:0] BIN_SCALE_RST   = 16'd4096;
  localparam logic [59:0] VAR_LOW_RST     = {20'h10000, 20'h10000, 20'h10000};
  localparam logic [39:0] VAR_HIGH_RST    = {20'h10000, 20'h10000};

  localparam logic [23:0] FLUX_EDGE0 = 24'd5000;
  localparam logic [23:0] FLUX_EDGE1 = 24'd10000;
  localparam logic [23:0] FLUX_EDGE2 = 24'd16000;
  localparam logic [23:0] FLUX_EDGE3 = 24'd22000;

  localparam logic signed [39:0] ONE_Q24 = 40'sd16777216;
  localparam logic signed [63:0] COV_MAX = 64'sd549755813887;
  localparam logic signed [63:0] S32_MAX = 64'sd2147483647;
  localparam logic signed [63:0] S32_MIN = -64'sd2147483648;

  localparam logic [3:0] MOP_VEL_DAMP = 4'd0;
  localparam logic [3:0] MOP_SUM_DAMP = 4'd1;
  localparam logic [3:0] MOP_CV_DAMP  = 4'd2;
  localparam logic [3:0] MOP_T_DAMP   = 4'd3;
  localparam logic [3:0] MOP_K0E      = 4'd4;
  localparam logic [3:0] MOP_K1E      = 4'd5;
  localparam logic [3:0] MOP_P00      = 4'd6;
  localparam logic [3:0] MOP_P01      = 4'd7;
  localparam logic [3:0] MOP_K1P01    = 4'd8;

  typedef struct packed {
    logic       capture;
    logic       init;
    logic       pred_upd;
    logic       prep;
    logic       sum;
    logic       mul_start;
    logic [3:0] mop;
    logic       div_start;
    logic       div_sel;
    logic       corr_upd;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic locked;
    logic full;
    logic bright;
    logic s_pos;
    logic mul_done;
    logic div_done;
    logic out_free;
  } status_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    logic signed [31:0] r;
    if (x > S32_MAX) r = 32'sh7FFFFFFF;
    else if (x < S32_MIN) r = 32'sh80000000;
    else r = x[31:0];
    return r;
  endfunction

  function automatic logic signed [39:0] satc(input logic signed [63:0] x);
    logic signed [39:0] r;
    if (x > COV_MAX) r = COV_MAX[39:0];
    else if (x < -COV_MAX) r = 40'(-COV_MAX);
    else r = x[39:0];
    return r;
  endfunction

  function automatic logic [63:0] mag64(input logic signed [63:0] x);
    logic [63:0] r;
    r = x[63] ? 64'(-x) : 64'(x);
    return r;
  endfunction

endpackage

/* rtl/dkpt_mul.sv */
// Shared multi-cycle multiplier: rounded, shifted and capped product of two magnitudes.
// Uses dkpt_pkg; built from four registered 32 by 32 partial products.
module dkpt_mul (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [63:0]        a_mag,
  input  logic [63:0]        b_mag,
  input  logic               neg,
  input  logic               sh24,
  output logic               done,
  output logic signed [63:0] prod
);
  import dkpt_pkg::*;

  logic [63:0]  am, bm;
  logic         ng, s24, busy;
  logic [2:0]   cnt;
  logic [63:0]  pp;
  logic [1:0]   pp_off;
  logic [127:0] acc;
  logic [31:0]  a_sel, b_sel;
  logic [63:0]  pp_next;
  logic [127:0] pp_shifted, rnd, shifted;
  logic [63:0]  m;

  always_comb begin
    unique case (cnt)
      3'd1: begin a_sel = am[31:0]; b_sel = bm[63:32]; end
      3'd2: begin a_sel = am[63:32]; b_sel = bm[31:0]; end
      3'd3: begin a_sel = am[63:32]; b_sel = bm[63:32]; end
      default: begin a_sel = am[31:0]; b_sel = bm[31:0]; end
    endcase
    pp_next = a_sel * b_sel;
    unique case (pp_off)
      2'd1: pp_shifted = {32'b0, pp, 32'b0};
      2'd2: pp_shifted = {pp, 64'b0};
      default: pp_shifted = {64'b0, pp};
    endcase
    rnd = acc + (s24 ? 128'h80_0000 : 128'h8000);
    shifted = s24 ? (rnd >> 24) : (rnd >> 16);
    m = (shifted > 128'h4000_0000_0000_0000) ? 64'h4000_0000_0000_0000 : shifted[63:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= 3'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        am   <= a_mag;
        bm   <= b_mag;
        ng   <= neg;
        s24  <= sh24;
        busy <= 1'b1;
        cnt  <= 3'd0;
        acc  <= 128'b0;
      end else if (busy) begin
        if (cnt < 3'd4) begin
          pp     <= pp_next;
          pp_off <= (cnt == 3'd0) ? 2'd0 : ((cnt == 3'd3) ? 2'd2 : 2'd1);
        end
        if (cnt >= 3'd1 && cnt <= 3'd4) begin
          acc <= acc + pp_shifted;
        end
        if (cnt == 3'd5) begin
          prod <= ng ? -$signed(m) : $signed(m);
          done <= 1'b1;
          busy <= 1'b0;
        end else begin
          cnt <= cnt + 3'd1;
        end
      end
    end
  end

endmodule

/* rtl/dkpt_div.sv */
// Restoring divider for the Kalman gains: round(num * 2^24 / den), one quotient bit a cycle.
// Uses dkpt_pkg; the denominator is positive and below 2^40.
module dkpt_div (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [39:0]        num_mag,
  input  logic [39:0]        den,
  input  logic               neg,
  output logic               done,
  output logic signed [63:0] quot
);
  import dkpt_pkg::*;

  logic [63:0] dvd, q;
  logic [39:0] rem, dv;
  logic [5:0]  cnt;
  logic        busy, ng;
  logic [40:0] trial;
  logic        qbit;
  logic [39:0] rem_next;
  logic [63:0] q_next;

  always_comb begin
    trial    = {rem, dvd[63]};
    qbit     = (trial >= {1'b0, dv});
    rem_next = qbit ? 40'(trial - {1'b0, dv}) : trial[39:0];
    q_next   = {q[62:0], qbit};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= 6'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        dvd  <= {num_mag, 24'b0} + {25'b0, den[39:1]};
        dv   <= den;
        ng   <= neg;
        rem  <= 40'b0;
        q    <= 64'b0;
        cnt  <= 6'd0;
        busy <= 1'b1;
      end else if (busy) begin
        rem <= rem_next;
        q   <= q_next;
        dvd <= {dvd[62:0], 1'b0};
        cnt <= cnt + 6'd1;
        if (cnt == 6'd63) begin
          quot <= ng ? -$signed(q_next) : $signed(q_next);
          done <= 1'b1;
          busy <= 1'b0;
        end
      end
    end
  end

endmodule

/* rtl/dkpt_datapath.sv */
// Datapath of the tracker: configuration registers, filter state, gain and product
// registers and the output register. Uses dkpt_pkg, dkpt_mul and dkpt_div.
module dkpt_datapath (
  input  logic                       clk,
  input  logic                       rst,
  input  dkpt_pkg::cmd_t             cmd,
  output dkpt_pkg::status_t          status,
  input  logic                       cfg_valid,
  input  logic [dkpt_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [63:0]                cfg_data,
  input  logic signed [31:0]         measurement,
  input  logic [23:0]                flux,
  input  logic                       full_frame,
  input  logic                       bright_frame,
  input  logic                       first_of_run,
  output logic                       est_valid,
  input  logic                       est_stall,
  output logic signed [31:0]         position_estimate,
  output logic signed [31:0]         velocity_estimate,
  output logic                       tracking,
  output logic                       corrected
);
  import dkpt_pkg::*;

  logic [31:0] accel_noise, full_frame_noise;
  logic [16:0] velocity_damping;
  logic [15:0] bin_noise_scale;
  logic [59:0] bias_bins_low, variance_bins_low;
  logic [39:0] bias_bins_high, variance_bins_high;

  logic signed [31:0] position, velocity, z;
  logic signed [39:0] cov_pos, cov_cross, cov_vel;
  logic               locked, corr_flag;
  logic [23:0]        flux_r;
  logic               full_r, bright_r;
  logic [31:0]        r;
  logic signed [40:0] s;
  logic signed [32:0] e;
  logic signed [63:0] k0, k1, t0, t1, t2, t3, t4;

  logic [19:0]        bias_raw, var_raw;
  logic [35:0]        rv_prod;
  logic signed [63:0] a_sum, one_minus_k0, op_a, op_b;
  logic               op_sh24;
  logic               mul_done, div_done;
  logic signed [63:0] mul_prod, div_quot;
  logic signed [39:0] div_num;

  always_comb begin
    if (flux_r < FLUX_EDGE0) begin
      bias_raw = bias_bins_low[19:0];
      var_raw  = variance_bins_low[19:0];
    end else if (flux_r < FLUX_EDGE1) begin
      bias_raw = bias_bins_low[39:20];
      var_raw  = variance_bins_low[39:20];
    end else if (flux_r < FLUX_EDGE2) begin
      bias_raw = bias_bins_low[59:40];
      var_raw  = variance_bins_low[59:40];
    end else if (flux_r < FLUX_EDGE3) begin
      bias_raw = bias_bins_high[19:0];
      var_raw  = variance_bins_high[19:0];
    end else begin
      bias_raw = bias_bins_high[39:20];
      var_raw  = variance_bins_high[39:20];
    end
    rv_prod      = var_raw * bin_noise_scale;
    a_sum        = 64'(cov_pos) + (64'(cov_cross) <<< 1) + 64'(cov_vel);
    one_minus_k0 = 64'(ONE_Q24) - k0;
    op_sh24      = 1'b1;
    unique case (cmd.mop)
      MOP_VEL_DAMP: begin
        op_a = 64'(velocity); op_b = $signed(64'(velocity_damping)); op_sh24 = 1'b0;
      end
      MOP_SUM_DAMP: begin
        op_a = 64'(cov_cross) + 64'(cov_vel); op_b = $signed(64'(velocity_damping));
        op_sh24 = 1'b0;
      end
      MOP_CV_DAMP: begin
        op_a = 64'(cov_vel); op_b = $signed(64'(velocity_damping)); op_sh24 = 1'b0;
      end
      MOP_T_DAMP: begin
        op_a = t2; op_b = $signed(64'(velocity_damping)); op_sh24 = 1'b0;
      end
      MOP_K0E:   begin op_a = k0; op_b = 64'(e); end
      MOP_K1E:   begin op_a = k1; op_b = 64'(e); end
      MOP_P00:   begin op_a = one_minus_k0; op_b = 64'(cov_pos); end
      MOP_P01:   begin op_a = one_minus_k0; op_b = 64'(cov_cross); end
      default:   begin op_a = k1; op_b = 64'(cov_cross); end
    endcase
    div_num = cmd.div_sel ? cov_cross : cov_pos;
  end

  dkpt_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.mul_start),
    .a_mag (mag64(op_a)),
    .b_mag (mag64(op_b)),
    .neg   (op_a[63] ^ op_b[63]),
    .sh24  (op_sh24),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  dkpt_div u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (cmd.div_start),
    .num_mag (40'(mag64(64'(div_num)))),
    .den     (s[39:0]),
    .neg     (div_num[39]),
    .done    (div_done),
    .quot    (div_quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      accel_noise        <= ACCEL_NOISE_RST;
      velocity_damping   <= DAMPING_RST;
      full_frame_noise   <= FULL_NOISE_RST;
      bin_noise_scale    <= BIN_SCALE_RST;
      bias_bins_low      <= 60'b0;
      bias_bins_high     <= 40'b0;
      variance_bins_low  <= VAR_LOW_RST;
      variance_bins_high <= VAR_HIGH_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_ACCEL_NOISE:   accel_noise        <= cfg_data[31:0];
        CFG_DAMPING:       velocity_damping   <= cfg_data[16:0];
        CFG_FULL_NOISE:    full_frame_noise   <= cfg_data[31:0];
        CFG_BIN_SCALE:     bin_noise_scale    <= cfg_data[15:0];
        CFG_BIAS_LOW:      bias_bins_low      <= cfg_data[59:0];
        CFG_BIAS_HIGH:     bias_bins_high     <= cfg_data[39:0];
        CFG_VARIANCE_LOW:  variance_bins_low  <= cfg_data[59:0];
        default:           variance_bins_high <= cfg_data[39:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position  <= 32'sd0;
      velocity  <= 32'sd0;
      cov_pos   <= ONE_Q24;
      cov_cross <= 40'sd0;
      cov_vel   <= ONE_Q24;
      locked    <= 1'b0;
      corr_flag <= 1'b0;
    end else begin
      if (cmd.capture) begin
        z         <= measurement;
        flux_r    <= flux;
        full_r    <= full_frame;
        bright_r  <= bright_frame;
        corr_flag <= 1'b0;
        if (first_of_run) begin
          position  <= 32'sd0;
          velocity  <= 32'sd0;
          cov_pos   <= ONE_Q24;
          cov_cross <= 40'sd0;
          cov_vel   <= ONE_Q24;
          locked    <= 1'b0;
        end
      end
      if (cmd.init) begin
        position  <= z;
        velocity  <= 32'sd0;
        locked    <= 1'b1;
        corr_flag <= 1'b1;
      end
      if (cmd.pred_upd) begin
        position  <= sat32(64'(position) + 64'(velocity));
        velocity  <= sat32(t0);
        cov_pos   <= satc(64'(satc(a_sum)) + $signed(64'(accel_noise >> 2)));
        cov_cross <= satc(64'(satc(t1)) + $signed(64'(accel_noise >> 1)));
        cov_vel   <= satc(64'(satc(t2)) + $signed(64'(accel_noise)));
      end
      if (cmd.prep) begin
        if (full_r) begin
          r <= full_frame_noise;
        end else begin
          r <= rv_prod[35:4];
          z <= sat32(64'(z) - 64'($signed(bias_raw)));
        end
      end
      if (cmd.sum) begin
        s <= 41'(cov_pos) + $signed({9'b0, r});
        e <= 33'(z) - 33'(position);
      end
      if (div_done) begin
        if (cmd.div_sel) k1 <= div_quot;
        else k0 <= div_quot;
      end
      if (mul_done) begin
        unique case (cmd.mop)
          MOP_VEL_DAMP, MOP_K0E: t0 <= mul_prod;
          MOP_SUM_DAMP, MOP_K1E: t1 <= mul_prod;
          MOP_CV_DAMP, MOP_T_DAMP, MOP_P00: t2 <= mul_prod;
          MOP_P01: t3 <= mul_prod;
          default: t4 <= mul_prod;
        endcase
      end
      if (cmd.corr_upd) begin
        position  <= sat32(64'(position) + 64'(sat32(t0)));
        velocity  <= sat32(64'(velocity) + 64'(sat32(t1)));
        cov_pos   <= satc(t2);
        cov_cross <= satc(t3);
        cov_vel   <= satc(64'(cov_vel) - t4);
        corr_flag <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      est_valid <= 1'b0;
    end else if (cmd.out_load) begin
      est_valid <= 1'b1;
    end else if (!est_stall) begin
      est_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      position_estimate <= position;
      velocity_estimate <= velocity;
      tracking          <= locked;
      corrected         <= corr_flag;
    end
  end

  always_comb begin
    status.locked   = locked;
    status.full     = full_r;
    status.bright   = bright_r;
    status.s_pos    = !s[40] && (s != 41'sd0);
    status.mul_done = mul_done;
    status.div_done = div_done;
    status.out_free = !est_valid || !est_stall;
  end

endmodule

/* rtl/dkpt_ctrl.sv */
// Controller state machine that sequences capture, prediction, gain division and correction.
// Uses dkpt_pkg; drives the datapath through cmd_t and reads status_t.
module dkpt_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              meas_valid,
  output logic              busy,
  output dkpt_pkg::cmd_t    cmd,
  input  dkpt_pkg::status_t status
);
  import dkpt_pkg::*;

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_BRANCH    = 4'd1;
  localparam logic [3:0] S_MUL_ISSUE = 4'd2;
  localparam logic [3:0] S_MUL_WAIT  = 4'd3;
  localparam logic [3:0] S_PRED_UPD  = 4'd4;
  localparam logic [3:0] S_PREP      = 4'd5;
  localparam logic [3:0] S_SUM       = 4'd6;
  localparam logic [3:0] S_DIV_ISSUE = 4'd7;
  localparam logic [3:0] S_DIV_WAIT  = 4'd8;
  localparam logic [3:0] S_CORR_UPD  = 4'd9;
  localparam logic [3:0] S_DONE      = 4'd10;

  logic [3:0] state, state_next, mop, mop_next;
  logic       dsel, dsel_next;

  always_comb begin
    state_next = state;
    mop_next   = mop;
    dsel_next  = dsel;
    cmd        = '0;
    cmd.mop    = mop;
    cmd.div_sel = dsel;
    unique case (state)
      S_IDLE: begin
        cmd.capture = meas_valid;
        if (meas_valid) state_next = S_BRANCH;
      end
      S_BRANCH: begin
        if (!status.locked) begin
          cmd.init   = status.full;
          state_next = S_DONE;
        end else begin
          mop_next   = MOP_VEL_DAMP;
          state_next = S_MUL_ISSUE;
        end
      end
      S_MUL_ISSUE: begin
        cmd.mul_start = 1'b1;
        state_next    = S_MUL_WAIT;
      end
      S_MUL_WAIT: begin
        if (status.mul_done) begin
          if (mop == MOP_T_DAMP) begin
            state_next = S_PRED_UPD;
          end else if (mop == MOP_K1P01) begin
            state_next = S_CORR_UPD;
          end else begin
            mop_next   = mop + 4'd1;
            state_next = S_MUL_ISSUE;
          end
        end
      end
      S_PRED_UPD: begin
        cmd.pred_upd = 1'b1;
        state_next   = (status.full || status.bright) ? S_PREP : S_DONE;
      end
      S_PREP: begin
        cmd.prep   = 1'b1;
        state_next = S_SUM;
      end
      S_SUM: begin
        cmd.sum    = 1'b1;
        dsel_next  = 1'b0;
        state_next = S_DIV_ISSUE;
      end
      S_DIV_ISSUE: begin
        if (!status.s_pos) begin
          state_next = S_DONE;
        end else begin
          cmd.div_start = 1'b1;
          state_next    = S_DIV_WAIT;
        end
      end
      S_DIV_WAIT: begin
        if (status.div_done) begin
          if (dsel) begin
            mop_next   = MOP_K0E;
            state_next = S_MUL_ISSUE;
          end else begin
            dsel_next  = 1'b1;
            state_next = S_DIV_ISSUE;
          end
        end
      end
      S_CORR_UPD: begin
        cmd.corr_upd = 1'b1;
        state_next   = S_DONE;
      end
      S_DONE: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      mop   <= MOP_VEL_DAMP;
      dsel  <= 1'b0;
    end else begin
      state <= state_next;
      mop   <= mop_next;
      dsel  <= dsel_next;
    end
  end

  assign busy = (state != S_IDLE);

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> status.out_free)
    else $error("Result loaded over one not yet transferred.");

  a_mul_wait: assert property (@(posedge clk) disable iff (rst)
    status.mul_done |-> state == S_MUL_WAIT)
    else $error("Multiplier finished outside its wait state.");

  a_div_wait: assert property (@(posedge clk) disable iff (rst)
    status.div_done |-> state == S_DIV_WAIT)
    else $error("Divider finished outside its wait state.");

  a_one_unit: assert property (@(posedge clk) disable iff (rst)
    !(cmd.mul_start && cmd.div_start))
    else $error("Multiplier and divider started together.");

endmodule

/* rtl/damped_kalman_position_tracker_top.sv */
// Top level of the damped two-state Kalman position tracker.
// Uses dkpt_pkg and instantiates dkpt_ctrl and dkpt_datapath.
//
// Usage: one frame enters on the measurement channel (meas_valid, meas_stall) and
// one estimate leaves on the estimate channel (est_valid, est_stall). A transfer
// takes place on a rising edge with valid high and stall low. Configuration must be
// written on the cfg channel (cfg_valid, cfg_ready, cfg_index, cfg_data) by the user
// only while the block is idle, which it does not enforce; cfg_ready is always high.
// The time from frame transfer to estimate depends on the frame: shortest for a frame
// before tracking starts, longer for a frame that only predicts and longest for
// a correcting frame. It is set by the shared multiplier, used for each of up to
// nine products, and by the restoring divider, used for each of the two gains.
// One frame is in work at a time, so a new frame waits until the last one is done.
// The estimate sits in an output register: the next frame is taken while it waits,
// and that frame's result is held back until the receiver lifts est_stall.
// Reset loads the default configuration, clears position and velocity, sets the
// covariance to identity and clears tracking.
module damped_kalman_position_tracker_top (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         meas_valid,
  output logic                         meas_stall,
  input  logic signed [31:0]           measurement,
  input  logic [23:0]                  flux,
  input  logic                         full_frame,
  input  logic                         bright_frame,
  input  logic                         first_of_run,
  output logic                         est_valid,
  input  logic                         est_stall,
  output logic signed [31:0]           position_estimate,
  output logic signed [31:0]           velocity_estimate,
  output logic                         tracking,
  output logic                         corrected,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [dkpt_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [63:0]                  cfg_data
);
  import dkpt_pkg::*;

  cmd_t    cmd;
  status_t status;

  assign cfg_ready = 1'b1;

  dkpt_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .meas_valid (meas_valid),
    .busy       (meas_stall),
    .cmd        (cmd),
    .status     (status)
  );

  dkpt_datapath u_datapath (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .status            (status),
    .cfg_valid         (cfg_valid),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .measurement       (measurement),
    .flux              (flux),
    .full_frame        (full_frame),
    .bright_frame      (bright_frame),
    .first_of_run      (first_of_run),
    .est_valid         (est_valid),
    .est_stall         (est_stall),
    .position_estimate (position_estimate),
    .velocity_estimate (velocity_estimate),
    .tracking          (tracking),
    .corrected         (corrected)
  );

endmodule

/* dv/dkpt_checker.sv */
// Checker for the damped Kalman position tracker: watches the frame, estimate and
// configuration channels, predicts each estimate and compares it field by field.
// Depends on dkpt_pkg for the register index constants, reset values and flux bin edges.
module dkpt_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               meas_valid,
  input  logic               meas_stall,
  input  logic signed [31:0] measurement,
  input  logic [23:0]        flux,
  input  logic               full_frame,
  input  logic               bright_frame,
  input  logic               first_of_run,
  input  logic               est_valid,
  input  logic               est_stall,
  input  logic signed [31:0] position_estimate,
  input  logic signed [31:0] velocity_estimate,
  input  logic               tracking,
  input  logic               corrected,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [dkpt_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [63:0]        cfg_data,
  output int                 errors,
  output int                 pending
);
  import dkpt_pkg::*;

  typedef struct {
    logic [31:0] pos;
    logic [31:0] vel;
    logic        trk;
    logic        cor;
  } estimate_t;

  localparam longint CovLimit = 64'sd549755813887;
  localparam longint OneQ24   = 64'sd16777216;

  estimate_t   est_queue[$];
  logic [31:0] accel_q;
  logic [16:0] damping;
  logic [31:0] full_noise;
  logic [15:0] bin_scale;
  logic [59:0] bias_low, var_low;
  logic [39:0] bias_high, var_high;
  longint      trk_pos, trk_vel, cov_pp, cov_pv, cov_vv;
  logic        locked;

  function automatic logic [63:0] mag_of(longint x);
    return x < 0 ? 64'(-x) : 64'(x);
  endfunction

  function automatic longint clip(longint x, longint lo, longint hi);
    return x < lo ? lo : (x > hi ? hi : x);
  endfunction

  function automatic longint clip32(longint x);
    return clip(x, -64'sd2147483648, 64'sd2147483647);
  endfunction

  function automatic longint clipc(longint x);
    return clip(x, -CovLimit, CovLimit);
  endfunction

  function automatic longint round_mul(longint a, longint b, int s);
    logic [127:0] p;
    logic [63:0]  m;
    p = 128'(mag_of(a)) * 128'(mag_of(b));
    p = (p + (128'd1 << (s - 1))) >> s;
    m = (p > (128'd1 << 62)) ? (64'd1 << 62) : p[63:0];
    return ((a < 0) != (b < 0)) ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint gain_of(longint num, longint den);
    logic [127:0] n;
    n = (128'(mag_of(num)) << 24) + 128'(den >>> 1);
    n = n / 128'(den);
    return num < 0 ? -longint'(n[63:0]) : longint'(n[63:0]);
  endfunction

  function automatic logic [19:0] bin_field(logic [59:0] lo, logic [39:0] hi, int b);
    return b < 3 ? lo[20*b +: 20] : hi[20*(b-3) +: 20];
  endfunction

  task automatic restart_track();
    trk_pos = 0;
    trk_vel = 0;
    cov_pp  = OneQ24;
    cov_pv  = 0;
    cov_vv  = OneQ24;
    locked  = 1'b0;
  endtask

  task automatic track_frame(output estimate_t res);
    longint z, d, q, a, b, c, r, s, k0, k1, e, p00, p01, bias;
    logic [19:0] braw;
    logic [63:0] noise;
    int bin;
    logic fixed;
    z = longint'(measurement);
    fixed = 1'b0;
    if (first_of_run) restart_track();
    if (!locked) begin
      if (full_frame) begin
        trk_pos = z;
        trk_vel = 0;
        locked  = 1'b1;
        fixed   = 1'b1;
      end
    end else begin
      d = longint'({47'd0, damping});
      q = longint'({32'd0, accel_q});
      a = cov_pp + 2 * cov_pv + cov_vv;
      b = round_mul(cov_pv + cov_vv, d, 16);
      c = round_mul(round_mul(cov_vv, d, 16), d, 16);
      trk_pos = clip32(trk_pos + trk_vel);
      trk_vel = clip32(round_mul(trk_vel, d, 16));
      cov_pp  = clipc(clipc(a) + (q >>> 2));
      cov_pv  = clipc(clipc(b) + (q >>> 1));
      cov_vv  = clipc(clipc(c) + q);
      if (full_frame || bright_frame) begin
        if (full_frame) begin
          r = longint'({32'd0, full_noise});
        end else begin
          if (flux < FLUX_EDGE0) bin = 0;
          else if (flux < FLUX_EDGE1) bin = 1;
          else if (flux < FLUX_EDGE2) bin = 2;
          else if (flux < FLUX_EDGE3) bin = 3;
          else bin = 4;
          braw  = bin_field(bias_low, bias_high, bin);
          bias  = longint'(signed'(braw));
          z     = clip32(z - bias);
          noise = (64'(bin_scale) * 64'(bin_field(var_low, var_high, bin))) >> 4;
          r     = longint'(noise);
        end
        s = cov_pp + r;
        if (s > 0) begin
          k0  = gain_of(cov_pp, s);
          k1  = gain_of(cov_pv, s);
          e   = z - trk_pos;
          p00 = cov_pp;
          p01 = cov_pv;
          trk_pos = clip32(trk_pos + clip32(round_mul(k0, e, 24)));
          trk_vel = clip32(trk_vel + clip32(round_mul(k1, e, 24)));
          cov_pp  = clipc(round_mul(OneQ24 - k0, p00, 24));
          cov_pv  = clipc(round_mul(OneQ24 - k0, p01, 24));
          cov_vv  = clipc(cov_vv - round_mul(k1, p01, 24));
          fixed   = 1'b1;
        end
      end
    end
    res.pos = trk_pos[31:0];
    res.vel = trk_vel[31:0];
    res.trk = locked;
    res.cor = fixed;
  endtask

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch on %s: got %h, expected %h", what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    estimate_t res, exp_est;
    if (rst) begin
      accel_q    <= ACCEL_NOISE_RST;
      damping    <= DAMPING_RST;
      full_noise <= FULL_NOISE_RST;
      bin_scale  <= BIN_SCALE_RST;
      bias_low   <= '0;
      bias_high  <= '0;
      var_low    <= VAR_LOW_RST;
      var_high   <= VAR_HIGH_RST;
      restart_track();
      est_queue.delete();
      errors  <= 0;
      pending <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_ACCEL_NOISE:   accel_q    <= cfg_data[31:0];
          CFG_DAMPING:       damping    <= cfg_data[16:0];
          CFG_FULL_NOISE:    full_noise <= cfg_data[31:0];
          CFG_BIN_SCALE:     bin_scale  <= cfg_data[15:0];
          CFG_BIAS_LOW:      bias_low   <= cfg_data[59:0];
          CFG_BIAS_HIGH:     bias_high  <= cfg_data[39:0];
          CFG_VARIANCE_LOW:  var_low    <= cfg_data[59:0];
          CFG_VARIANCE_HIGH: var_high   <= cfg_data[39:0];
          default: ;
        endcase
      end
      if (meas_valid && !meas_stall) begin
        track_frame(res);
        est_queue.push_back(res);
      end
      if (est_valid && !est_stall) begin
        if (est_queue.size() == 0) begin
          $display("estimate transfer with no frame outstanding");
          errors++;
        end else begin
          exp_est = est_queue.pop_front();
          if (position_estimate !== exp_est.pos)
            report("position", position_estimate, exp_est.pos);
          if (velocity_estimate !== exp_est.vel)
            report("velocity", velocity_estimate, exp_est.vel);
          if (tracking !== exp_est.trk) report("tracking", 32'(tracking), 32'(exp_est.trk));
          if (corrected !== exp_est.cor) report("corrected", 32'(corrected), 32'(exp_est.cor));
        end
      end
      pending <= est_queue.size();
    end
  end

endmodule

/* dv/tb_top.sv */
// Testbench top for the damped Kalman position tracker: generates clock, reset,
// frames, receiver stalls and configuration phases, and gives the verdict.
// Depends on dkpt_pkg, damped_kalman_position_tracker_top and dkpt_checker.
module tb_top;
  import dkpt_pkg::*;

  localparam int IdleLimit = 6000;

  logic               clk, rst;
  logic               meas_valid, meas_stall;
  logic signed [31:0] measurement;
  logic [23:0]        flux;
  logic               full_frame, bright_frame, first_of_run;
  logic               est_valid, est_stall;
  logic signed [31:0] position_estimate, velocity_estimate;
  logic               tracking, corrected;
  logic               cfg_valid, cfg_ready;
  logic [CfgIdxW-1:0] cfg_index;
  logic [63:0]        cfg_data;
  int                 errors, pending, idle_cycles, burst_left, stall_left, stall_mode;
  logic [31:0]        path_pos;

  damped_kalman_position_tracker_top DUT (.*);

  dkpt_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst || (meas_valid && !meas_stall) || (est_valid && !est_stall)
        || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_left <= $urandom_range(1, 40);
      stall_mode <= $urandom_range(0, 3);
      est_stall  <= 1'b0;
    end else begin
      stall_left <= stall_left - 1;
      case (stall_mode)
        0: est_stall <= 1'b0;
        1: est_stall <= 1'b1;
        default: est_stall <= 1'($urandom_range(0, 1));
      endcase
    end
  end

  task automatic send_frame(logic [31:0] m, logic [23:0] f, logic full, logic bright,
                            logic first);
    if (burst_left == 0) begin
      meas_valid <= 1'b0;
      repeat ($urandom_range(1, 30)) @(negedge clk);
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    meas_valid   <= 1'b1;
    measurement  <= m;
    flux         <= f;
    full_frame   <= full;
    bright_frame <= bright;
    first_of_run <= first;
    do @(posedge clk); while (meas_stall);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [63:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    meas_valid <= 1'b0;
    burst_left = 0;
    while (pending != 0 || meas_valid) @(negedge clk);
    repeat (250) @(negedge clk);
  endtask

  task automatic load_setting(logic [31:0] q, logic [16:0] d, logic [31:0] fn,
                              logic [15:0] sc, logic [59:0] bl, logic [39:0] bh,
                              logic [59:0] vl, logic [39:0] vh);
    wait_drained();
    write_reg(CFG_ACCEL_NOISE, 64'(q));
    write_reg(CFG_DAMPING, 64'(d));
    write_reg(CFG_FULL_NOISE, 64'(fn));
    write_reg(CFG_BIN_SCALE, 64'(sc));
    write_reg(CFG_BIAS_LOW, 64'(bl));
    write_reg(CFG_BIAS_HIGH, 64'(bh));
    write_reg(CFG_VARIANCE_LOW, 64'(vl));
    write_reg(CFG_VARIANCE_HIGH, 64'(vh));
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [23:0] pick_flux();
    case ($urandom_range(0, 7))
      0: return 24'($urandom_range(0, 4999));
      1: return 24'($urandom_range(5000, 9999));
      2: return 24'($urandom_range(10000, 15999));
      3: return 24'($urandom_range(16000, 21999));
      4: return 24'($urandom_range(22000, 40000));
      5: return 24'($urandom);
      default: begin
        case ($urandom_range(0, 3))
          0: return $urandom_range(0, 1) ? 24'd4999 : 24'd5000;
          1: return $urandom_range(0, 1) ? 24'd9999 : 24'd10000;
          2: return $urandom_range(0, 1) ? 24'd15999 : 24'd16000;
          default: return $urandom_range(0, 1) ? 24'd21999 : 24'd22000;
        endcase
      end
    endcase
  endfunction

  task automatic random_frames(int count);
    logic [31:0] m;
    logic full, bright, first;
    int sel;
    for (int i = 0; i < count; i++) begin
      first = ($urandom_range(0, 39) == 0);
      sel   = $urandom_range(0, 9);
      full  = (sel < 4);
      bright = (sel >= 3 && sel < 8);
      path_pos = path_pos + 32'($urandom_range(0, 131072)) - 32'd65536;
      if ($urandom_range(0, 7) == 0) m = $urandom;
      else m = path_pos + 32'($urandom_range(0, 65536)) - 32'd32768;
      send_frame(m, pick_flux(), full, bright, first);
    end
  endtask

  task automatic random_setting();
    load_setting($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 200000),
                 17'($urandom_range(0, 65536)),
                 $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 20000000),
                 16'($urandom),
                 60'({$urandom, $urandom}), 40'({$urandom, $urandom}),
                 60'({$urandom, $urandom}), 40'({$urandom, $urandom}));
  endtask

  initial begin
    rst = 1'b1;
    meas_valid = 1'b0;
    measurement = '0;
    flux = '0;
    full_frame = 1'b0;
    bright_frame = 1'b0;
    first_of_run = 1'b0;
    est_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = CFG_ACCEL_NOISE;
    cfg_data = '0;
    idle_cycles = 0;
    burst_left = 0;
    stall_left = 0;
    stall_mode = 0;
    path_pos = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_frame(32'h1234_5678, 24'd0, 1'b0, 1'b0, 1'b0);
    send_frame(32'h0001_0000, 24'd100, 1'b0, 1'b1, 1'b0);
    send_frame(32'h7FFF_FFFF, 24'd0, 1'b1, 1'b0, 1'b0);
    send_frame(32'h0, 24'd0, 1'b0, 1'b0, 1'b0);
    send_frame(32'h8000_0000, 24'd0, 1'b1, 1'b1, 1'b0);
    send_frame(32'hFFFF_0000, 24'd4999, 1'b0, 1'b1, 1'b0);
    send_frame(32'hFFFF_0000, 24'd5000, 1'b0, 1'b1, 1'b0);
    send_frame(32'h0002_0000, 24'd9999, 1'b0, 1'b1, 1'b0);
    send_frame(32'h0002_0000, 24'd10000, 1'b0, 1'b1, 1'b0);
    send_frame(32'h0003_0000, 24'd15999, 1'b0, 1'b1, 1'b0);
    send_frame(32'h0003_0000, 24'd16000, 1'b0, 1'b1, 1'b0);
    send_frame(32'h0004_0000, 24'd21999, 1'b0, 1'b1, 1'b0);
    send_frame(32'h0004_0000, 24'd22000, 1'b0, 1'b1, 1'b0);
    send_frame(32'h0005_0000, 24'hFFFFFF, 1'b0, 1'b1, 1'b0);
    send_frame(32'h0, 24'd0, 1'b0, 1'b0, 1'b1);
    send_frame(32'h0, 24'd0, 1'b1, 1'b0, 1'b1);
    send_frame(32'h0064_0000, 24'd0, 1'b1, 1'b0, 1'b0);
    send_frame(32'h00C8_0000, 24'd0, 1'b1, 1'b0, 1'b0);
    send_frame(32'h012C_0000, 24'd0, 1'b0, 1'b0, 1'b0);
    random_frames(80);

    load_setting(32'd0, 17'd0, 32'd0, 16'd0, '0, '0, '0, '0);
    send_frame(32'h0010_0000, 24'd0, 1'b1, 1'b0, 1'b1);
    repeat (6) send_frame(32'h0020_0000, 24'd0, 1'b1, 1'b0, 1'b0);
    send_frame(32'h0020_0000, 24'd0, 1'b0, 1'b1, 1'b0);
    random_frames(95);

    load_setting(32'hFFFF_FFFF, 17'd65536, 32'hFFFF_FFFF, 16'hFFFF,
                 {20'h80000, 20'h7FFFF, 20'hFFFFF}, {20'h80000, 20'h7FFFF},
                 {60{1'b1}}, {40{1'b1}});
    random_frames(100);

    for (int p = 0; p < 8; p++) begin
      random_setting();
      random_frames(105);
    end

    load_setting(ACCEL_NOISE_RST, DAMPING_RST, FULL_NOISE_RST, BIN_SCALE_RST,
                 {20'h00800, 20'hFF800, 20'h7FFFF}, {20'h80000, 20'h01000},
                 VAR_LOW_RST, VAR_HIGH_RST);
    random_frames(100);

    meas_valid <= 1'b0;
    while (pending != 0 || meas_valid) @(negedge clk);
    repeat (300) @(negedge clk);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/dkpt_pkg.sv
rtl/dkpt_mul.sv
rtl/dkpt_div.sv
rtl/dkpt_datapath.sv
rtl/dkpt_ctrl.sv
rtl/damped_kalman_position_tracker_top.sv
dv/dkpt_checker.sv
dv/tb_top.sv
